>>> rtl/core/ima_adpcm_block_decoder_macros.svh
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder assertion macros
// Shared property wrappers for the decoder checks. Each use expects clk and
// rst_n in scope and is disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_BLOCK_DECODER_MACROS_SVH

// Same-cycle implication.
`define IMADEC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imadec check failed");

// Next-cycle implication.
`define IMADEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imadec check failed");

`endif

>>> rtl/core/imadec_pkg.sv
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder package
// Sizes, limits, the quantizer step table and the shared decoder state type.
// ---------------------------------------------------------------------------
`default_nettype none

package imadec_pkg;

    localparam int HEADER_BYTES  = 4;
    localparam int BLOCK_SAMPLES = 1024;

    // header byte positions
    localparam int HDR_PRED_LO = 0;
    localparam int HDR_PRED_HI = 1;
    localparam int HDR_INDEX   = 2;

    localparam int LIM_W  = 11;
    localparam int HPOS_W = $clog2(HEADER_BYTES + 1);
    localparam int CNT_W  = $clog2(BLOCK_SAMPLES + 1);
    localparam int CMP_W  = (LIM_W > CNT_W) ? LIM_W : CNT_W;

    localparam int BYTE_W     = 8;
    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 7;
    localparam int STEP_W     = 15;
    localparam int S_TDATA_W  = ((BYTE_W + LIM_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = SAMPLE_W;
    localparam int M_TUSER_W  = 2;

    localparam int IDX_MAX = 88;
    localparam int PCM_MAX = 32767;
    localparam int PCM_MIN = -32768;

    localparam logic [STEP_W-1:0] STEP_TAB [0:IDX_MAX] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16,
        15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37,
        15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88,
        15'd97, 15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190,
        15'd209, 15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408,
        15'd449, 15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876,
        15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707,
        15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327,
        15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pred;
        logic [IDX_W-1:0]           idx;
    } imadec_state_t;

    function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        if (idx > IDX_W'(IDX_MAX))
            s = STEP_TAB[IDX_MAX];
        else
            s = STEP_TAB[idx];
        return s;
    endfunction

    // step index adjustment for the magnitude bits of a code
    function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ima_adpcm_block_decoder.sv
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder
// Decodes a stream of IMA/DVI 4-bit ADPCM block bytes into 16-bit PCM words.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Word contents (lowest bit first)
//  -------  ---  ---------------------------------------------------------
//  s_axis   in   tdata: data_byte[7:0], sample_limit[18:8], zero pad
//                tuser: first_byte; tlast: last_byte
//  m_axis   out  tdata: sample[15:0]; tuser: error, run_end; tlast: block_end
//
//  Each accepted word sits in an input register; one nibble is decoded per
//  cycle into the result register. A data byte gives one sample per nibble
//  (2 at most, 1 when the limit trims it); a header byte gives at most the
//  seed sample or an error word, and an ignored byte gives none.
//  The next input word is taken in the cycle its predecessor retires.
//  A full result register that is not taken stalls the decode; words that
//  give no result still retire.
//  Reset (rst_n low, asynchronous) empties both registers and leaves the
//  decoder waiting for a first_byte.
// ---------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_block_decoder
    import imadec_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 s_axis_tvalid,
    output      logic                 s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // data_byte, sample_limit, pad
    input  wire logic                 s_axis_tuser,   // first_byte
    input  wire logic                 s_axis_tlast,   // last_byte

    output      logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output      logic [M_TDATA_W-1:0] m_axis_tdata,   // sample
    output      logic [M_TUSER_W-1:0] m_axis_tuser,   // error, run_end
    output      logic                 m_axis_tlast    // block_end
);

    // input register
    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_first_reg;
    logic                 in_last_reg;
    logic [LIM_W-1:0]     in_limit_reg;

    // decoder state
    imadec_state_t        st_reg, st_next;
    logic [HPOS_W-1:0]    hpos_reg, hpos_next;
    logic [CNT_W-1:0]     emitted_reg, emitted_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic                 done_reg, done_next;
    logic                 bad_reg, bad_next;
    logic                 hi_nib_reg, hi_nib_next;

    // result register
    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  out_sample_reg;
    logic                        out_block_end_reg;
    logic                        out_error_reg;
    logic                        out_run_end_reg;

    // effective state after a first_byte restart
    imadec_state_t        e_st;
    logic [HPOS_W-1:0]    e_hpos;
    logic [CNT_W-1:0]     e_emitted;
    logic [CNT_W-1:0]     e_limit;
    logic                 e_done;
    logic                 e_bad;
    logic [CNT_W-1:0]     capped_limit;

    imadec_state_t        dec_st;
    logic [3:0]           nib_code;
    logic [CNT_W-1:0]     emitted_inc;

    logic                 emit;
    logic                 item_done;
    logic                 step;
    logic                 out_free;
    logic signed [SAMPLE_W-1:0] res_sample;
    logic                 res_block_end;
    logic                 res_error;
    logic                 res_run_end;

    assign capped_limit = (CMP_W'(in_limit_reg) > CMP_W'(BLOCK_SAMPLES))
                        ? CNT_W'(BLOCK_SAMPLES) : CNT_W'(in_limit_reg);

    // a first_byte restarts the block; it only counts on the low-nibble pass
    always_comb
    begin
        if (in_first_reg && !hi_nib_reg)
        begin
            e_st      = '0;
            e_hpos    = '0;
            e_emitted = '0;
            e_limit   = capped_limit;
            e_done    = 1'b0;
            e_bad     = 1'b0;
        end
        else
        begin
            e_st      = st_reg;
            e_hpos    = hpos_reg;
            e_emitted = emitted_reg;
            e_limit   = limit_reg;
            e_done    = done_reg;
            e_bad     = bad_reg;
        end
    end

    assign nib_code    = hi_nib_reg ? in_byte_reg[7:4] : in_byte_reg[3:0];
    assign emitted_inc = e_emitted + 1'b1;

    imadec_nibble u_nibble (
        .cur  (e_st),
        .code (nib_code),
        .nxt  (dec_st)
    );

    // one pass over the held word: header bytes, data nibbles, closing at the limit, or drop
    always_comb
    begin
        st_next       = e_st;
        hpos_next     = e_hpos;
        emitted_next  = e_emitted;
        limit_next    = e_limit;
        done_next     = e_done;
        bad_next      = e_bad;
        hi_nib_next   = 1'b0;
        emit          = 1'b0;
        item_done     = 1'b1;
        res_sample    = '0;
        res_block_end = 1'b0;
        res_error     = 1'b0;
        res_run_end   = 1'b0;

        if (hi_nib_reg)
        begin
            // second sample of a data byte
            st_next       = dec_st;
            emitted_next  = emitted_inc;
            emit          = 1'b1;
            res_sample    = dec_st.pred;
            res_run_end   = 1'b1;
            res_block_end = in_last_reg || (emitted_inc >= e_limit);
            done_next     = res_block_end;
        end
        else if (e_done)
        begin
            // drop: no block open
        end
        else if (e_hpos < HPOS_W'(HEADER_BYTES))
        begin
            if (e_hpos == HPOS_W'(HDR_PRED_LO))
                st_next.pred = $signed({8'h00, in_byte_reg});
            else if (e_hpos == HPOS_W'(HDR_PRED_HI))
                st_next.pred = $signed({in_byte_reg, e_st.pred[7:0]});
            else if (e_hpos == HPOS_W'(HDR_INDEX))
            begin
                if (in_byte_reg > BYTE_W'(IDX_MAX))
                    bad_next = 1'b1;
                else
                    st_next.idx = IDX_W'(in_byte_reg);
            end
            hpos_next = e_hpos + 1'b1;

            if (hpos_next < HPOS_W'(HEADER_BYTES))
            begin
                if (in_last_reg)
                begin
                    // short header
                    emit          = 1'b1;
                    res_error     = 1'b1;
                    res_block_end = 1'b1;
                    res_run_end   = 1'b1;
                    done_next     = 1'b1;
                end
            end
            else if (bad_next || (e_limit == '0))
            begin
                emit          = 1'b1;
                res_error     = 1'b1;
                res_block_end = 1'b1;
                res_run_end   = 1'b1;
                done_next     = 1'b1;
            end
            else
            begin
                // emit the seed sample
                emitted_next  = CNT_W'(1);
                emit          = 1'b1;
                res_sample    = st_next.pred;
                res_run_end   = 1'b1;
                res_block_end = in_last_reg || (e_limit == CNT_W'(1));
                done_next     = res_block_end;
            end
        end
        else if (e_emitted >= e_limit)
        begin
            // limit reached: close the block quietly
            done_next = 1'b1;
        end
        else
        begin
            // low nibble
            st_next      = dec_st;
            emitted_next = emitted_inc;
            emit         = 1'b1;
            res_sample   = dec_st.pred;
            if (emitted_inc < e_limit)
            begin
                hi_nib_next = 1'b1;
                item_done   = 1'b0;
            end
            else
            begin
                res_run_end   = 1'b1;
                res_block_end = 1'b1;
                done_next     = 1'b1;
            end
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && (out_free || !emit);
    assign s_axis_tready = !in_valid_reg || (step && item_done);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (step && item_done)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata[BYTE_W-1:0];
            in_limit_reg <= s_axis_tdata[BYTE_W+LIM_W-1:BYTE_W];
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    // decoder state: advance on each pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            hpos_reg    <= '0;
            emitted_reg <= '0;
            limit_reg   <= '0;
            done_reg    <= 1'b1;
            bad_reg     <= 1'b0;
            hi_nib_reg  <= 1'b0;
        end
        else if (step)
        begin
            st_reg      <= st_next;
            hpos_reg    <= hpos_next;
            emitted_reg <= emitted_next;
            limit_reg   <= limit_next;
            done_reg    <= done_next;
            bad_reg     <= bad_next;
            hi_nib_reg  <= hi_nib_next;
        end
    end

    // result register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_sample_reg    <= res_sample;
            out_block_end_reg <= res_block_end;
            out_error_reg     <= res_error;
            out_run_end_reg   <= res_run_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = {out_run_end_reg, out_error_reg};
    assign m_axis_tlast  = out_block_end_reg;

endmodule

`default_nettype wire

>>> rtl/core/imadec_nibble.sv
// ---------------------------------------------------------------------------
// IMA ADPCM nibble decoder
// Applies one 4-bit code to the predictor and step index, with clamping.
// ---------------------------------------------------------------------------
`default_nettype none

module imadec_nibble
    import imadec_pkg::*;
(
    input  imadec_state_t cur,
    input  logic [3:0]    code,
    output imadec_state_t nxt
);

    logic [STEP_W-1:0]           step;
    logic [SAMPLE_W:0]           diff;
    logic signed [SAMPLE_W+1:0]  pred_sum;
    logic signed [IDX_W:0]       idx_sum;

    always_comb
    begin
        step = step_lookup(cur.idx);
        diff = (SAMPLE_W + 1)'(step >> 3);
        if (code[2])
            diff = diff + (SAMPLE_W + 1)'(step);
        if (code[1])
            diff = diff + (SAMPLE_W + 1)'(step >> 1);
        if (code[0])
            diff = diff + (SAMPLE_W + 1)'(step >> 2);

        if (code[3])
            pred_sum = (SAMPLE_W + 2)'(cur.pred) - $signed({1'b0, diff});
        else
            pred_sum = (SAMPLE_W + 2)'(cur.pred) + $signed({1'b0, diff});

        // clamp to the 16-bit PCM range
        if (pred_sum > (SAMPLE_W + 2)'(PCM_MAX))
            nxt.pred = SAMPLE_W'(PCM_MAX);
        else if (pred_sum < (SAMPLE_W + 2)'(PCM_MIN))
            nxt.pred = SAMPLE_W'(PCM_MIN);
        else
            nxt.pred = pred_sum[SAMPLE_W-1:0];

        idx_sum = $signed({1'b0, cur.idx}) + (IDX_W + 1)'(idx_adjust(code[2:0]));
        if (idx_sum < 0)
            nxt.idx = '0;
        else if (idx_sum > (IDX_W + 1)'(IDX_MAX))
            nxt.idx = IDX_W'(IDX_MAX);
        else
            nxt.idx = idx_sum[IDX_W-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/core/imadec_checker.sv
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder checker
// Port-level checks on the result stream, bound to the decoder top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ima_adpcm_block_decoder_macros.svh"

module imadec_checker
    import imadec_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    // an error word is zero and closes both the run and the block
    `IMADEC_ASSERT_SAME(a_error_word, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && m_axis_tlast && m_axis_tuser[1])

    // a block never ends in the middle of a byte's run
    `IMADEC_ASSERT_SAME(a_block_end_run, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1])

    // hold a stalled word
    `IMADEC_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    `IMADEC_ASSERT_NEXT(a_hold_flags, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind ima_adpcm_block_decoder imadec_checker u_imadec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
